// File: rtl/dtcf_pkg.sv
package dtcf_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned FracWidth = 52;
  localparam int unsigned DexpWidth = 11;
  localparam int unsigned EwWidth = 4;
  localparam int unsigned MwWidth = 6;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned BiasedWidth = 13;
  localparam int unsigned CfgIndexWidth = 1;

  localparam logic [DexpWidth-1:0] DexpAllOnes = 11'h7ff;
  localparam logic signed [BiasedWidth-1:0] DexpBias = 13'sd1023;
  localparam logic [EwWidth-1:0] EwReset = 4'd8;
  localparam logic [MwWidth-1:0] MwReset = 6'd23;
  localparam logic [EwWidth-1:0] EwMin = 4'd2;
  localparam logic [EwWidth-1:0] EwMax = 4'd11;
  localparam logic [MwWidth-1:0] MwMin = 6'd1;
  localparam logic [MwWidth-1:0] MwMax = 6'd52;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_EXPONENT_BITS = 1'b0,
    CFG_MANTISSA_BITS = 1'b1
  } cfg_index_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_NORMAL    = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FINITE = 2'd3
  } status_t;

  typedef struct packed {
    logic [EwWidth-1:0] ew;
    logic [MwWidth-1:0] mw;
  } fmt_t;

endpackage

// File: rtl/double_to_custom_float.sv
// double to custom float converter
// s_axis carries one ieee double bit pattern per item in tdata[63:0].
// m_axis returns one item per input: tdata[63:0] is the right-aligned
// result (sign, biased exponent, rounded fraction), tuser[1:0] the status
// (0 normal, 1 overflow, 2 underflow or zero, 3 input not finite).
// cfg writes exponent_bits (index 0) and mantissa_bits (index 1); write
// them only while the block is idle. cfg_data is cut to its low 4 or 6
// bits, then clamped to 2..11 and 1..52. one item is accepted every
// cycle while the output is not stalled. the pipeline is split into
// fraction shift and round-bit extraction, increment with exponent carry,
// and final packing. when the receiver holds tready low the whole
// pipeline holds, and s_axis_tready drops in every cycle in which the
// output register holds an item that the receiver does not take. reset
// clears all valid bits and loads exponent_bits=8, mantissa_bits=23.
module double_to_custom_float (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_bits
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import dtcf_pkg::*;

  logic [EwWidth-1:0] exponent_bits;
  logic [MwWidth-1:0] mantissa_bits;
  fmt_t               fmt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent_bits <= EwReset;
      mantissa_bits <= MwReset;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_EXPONENT_BITS: exponent_bits <= cfg_data[EwWidth-1:0];
        CFG_MANTISSA_BITS: mantissa_bits <= cfg_data[MwWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fmt.ew = (exponent_bits < EwMin) ? EwMin : ((exponent_bits > EwMax) ? EwMax : exponent_bits);
    fmt.mw = (mantissa_bits < MwMin) ? MwMin : ((mantissa_bits > MwMax) ? MwMax : mantissa_bits);
  end

  logic advance;
  logic b_valid;
  logic b_sign;
  logic signed [BiasedWidth-1:0] b_biased;
  logic [FracWidth-1:0] b_keep;
  fmt_t b_fmt;
  status_t b_special;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  dtcf_round u_round (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s_axis_tvalid),
    .in_value   (s_axis_tdata),
    .in_fmt     (fmt),
    .out_valid  (b_valid),
    .out_sign   (b_sign),
    .out_biased (b_biased),
    .out_keep   (b_keep),
    .out_fmt    (b_fmt),
    .out_special(b_special)
  );

  // final packing stage
  logic [ValueWidth-1:0] sign_pos;
  logic [ValueWidth-1:0] exp_max;
  logic signed [BiasedWidth-1:0] exp_max_s;
  logic [ValueWidth-1:0] pack;
  status_t st;

  always_comb begin
    sign_pos = {{(ValueWidth-1){1'b0}}, b_sign} << (b_fmt.ew + b_fmt.mw);
    exp_max = ({{(ValueWidth-1){1'b0}}, 1'b1} << b_fmt.ew) - 64'd1;
    exp_max_s = $signed({1'b0, exp_max[11:0]});
    if (b_special == ST_NOT_FINITE) begin
      pack = sign_pos | (exp_max << b_fmt.mw);
      st = ST_NOT_FINITE;
    end else if (b_special == ST_UNDERFLOW) begin
      pack = sign_pos;
      st = ST_UNDERFLOW;
    end else if (b_biased >= exp_max_s) begin
      pack = sign_pos | (exp_max << b_fmt.mw);
      st = ST_OVERFLOW;
    end else if (b_biased <= 13'sd0) begin
      pack = sign_pos;
      st = ST_UNDERFLOW;
    end else begin
      pack = sign_pos | ({51'd0, b_biased[12:0]} << b_fmt.mw) | {12'd0, b_keep};
      st = ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= b_valid;
    end
    if (advance) begin
      m_axis_tdata <= pack;
      m_axis_tuser <= st;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("output changed while stalled");
  // a signed zero has at most the sign bit set
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_UNDERFLOW |-> $onehot0(m_axis_tdata))
    else $error("underflow result malformed");
  assert property (@(posedge clk) disable iff (rst)
    advance && b_valid |=> m_axis_tvalid)
    else $error("item dropped at output");

endmodule

// File: rtl/dtcf_round.sv
module dtcf_round (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic [63:0]                   in_value,
  input  dtcf_pkg::fmt_t                in_fmt,
  output logic                          out_valid,
  output logic                          out_sign,
  output logic signed [12:0]            out_biased,
  output logic [51:0]                   out_keep,
  output dtcf_pkg::fmt_t                out_fmt,
  output dtcf_pkg::status_t             out_special
);
  import dtcf_pkg::*;

  // stage a: split, shift fraction, rounding bits
  logic                 a_valid;
  logic                 a_sign;
  logic [DexpWidth-1:0] a_dexp;
  logic [FracWidth-1:0] a_keep;
  logic                 a_up;
  fmt_t                 a_fmt;

  logic [FracWidth-1:0] frac;
  logic [MwWidth-1:0]   sh;
  logic [FracWidth-1:0] rem_mask;
  logic [FracWidth-1:0] rem;
  logic [FracWidth-1:0] half;
  logic [FracWidth-1:0] keep_c;

  always_comb begin
    frac = in_value[FracWidth-1:0];
    sh = MwMax - in_fmt.mw;
    keep_c = frac >> sh;
    rem_mask = ~({FracWidth{1'b1}} << sh);
    rem = frac & rem_mask;
    half = (sh == '0) ? '0 : ({{(FracWidth-1){1'b0}}, 1'b1} << (sh - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
    if (advance) begin
      a_sign <= in_value[63];
      a_dexp <= in_value[62:FracWidth];
      a_keep <= keep_c;
      a_up <= (sh != '0) && ((rem > half) || (rem == half && keep_c[0]));
      a_fmt <= in_fmt;
    end
  end

  // stage b: increment and carry into exponent
  logic [FracWidth:0]           inc;
  logic                         carry;
  logic signed [BiasedWidth-1:0] bias;

  always_comb begin
    inc = {1'b0, a_keep} + {{FracWidth{1'b0}}, a_up};
    carry = inc[a_fmt.mw];
    bias = BiasedWidth'((13'sd1 <<< (a_fmt.ew - 1'b1)) - 13'sd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid;
    end
    if (advance) begin
      out_sign <= a_sign;
      out_keep <= carry ? '0 : inc[FracWidth-1:0];
      out_biased <= $signed({2'b00, a_dexp}) - DexpBias + bias
                    + $signed({12'd0, carry});
      out_fmt <= a_fmt;
      out_special <= (a_dexp == DexpAllOnes) ? ST_NOT_FINITE :
                     ((a_dexp == '0) ? ST_UNDERFLOW : ST_NORMAL);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    a_valid && advance && carry |=> out_keep == '0)
    else $error("rounding carry left fraction bits");
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(out_biased) && $stable(out_valid))
    else $error("stage changed during stall");
  assert property (@(posedge clk) disable iff (rst)
    advance && a_valid |=> out_valid)
    else $error("item lost between stages");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dtcf_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // value_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // result_bits
  logic [1:0]  m_axis_tuser;    // status
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  typedef struct {
    logic [63:0] bits;
    status_t     st;
  } conv_t;

  conv_t       pending_q[$];
  logic [3:0]  ew_reg;
  logic [5:0]  mw_reg;
  int          errors = 0;
  bit          rx_hold;
  bit          rx_random;
  event        hold_go;

  double_to_custom_float i_dut (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic conv_t convert(logic [63:0] v);
    conv_t r;
    int unsigned e, m, sh;
    logic [63:0] spos, emax, keep, rem, half;
    longint biased, bias;
    logic [10:0] dexp;
    logic [51:0] frac;
    e = (ew_reg < 2) ? 2 : (ew_reg > 11) ? 11 : ew_reg;
    m = (mw_reg < 1) ? 1 : (mw_reg > 52) ? 52 : mw_reg;
    dexp = v[62:52];
    frac = v[51:0];
    spos = 64'(v[63]) << (e + m);
    emax = (64'd1 << e) - 1;
    bias = (longint'(1) << (e - 1)) - 1;
    if (dexp == 11'h7ff) begin
      r.bits = spos | (emax << m);
      r.st = ST_NOT_FINITE;
      return r;
    end
    if (dexp == 0) begin
      r.bits = spos;
      r.st = ST_UNDERFLOW;
      return r;
    end
    biased = longint'(dexp) - 1023 + bias;
    keep = 64'(frac);
    if (m != 52) begin
      sh = 52 - m;
      rem = keep & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = keep >> sh;
      if (rem > half || (rem == half && keep[0])) begin
        keep = keep + 1;
        if (keep == (64'd1 << m)) begin
          keep = 0;
          biased = biased + 1;
        end
      end
    end
    if (biased >= longint'(emax)) begin
      r.bits = spos | (emax << m);
      r.st = ST_OVERFLOW;
    end else if (biased <= 0) begin
      r.bits = spos;
      r.st = ST_UNDERFLOW;
    end else begin
      r.bits = spos | (64'(biased) << m) | keep;
      r.st = ST_NORMAL;
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // long receiver hold, counted here
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_go);
      rx_hold = 1'b1;
      repeat (40) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  // result checker and receiver stall control
  initial begin
    int wait_n;
    m_axis_tready = 1'b0;
    wait_n = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          report("unexpected item", m_axis_tdata, 64'd0);
        end else begin
          conv_t w;
          w = pending_q.pop_front();
          if (m_axis_tdata !== w.bits) report("result_bits", m_axis_tdata, w.bits);
          if (m_axis_tuser !== w.st) report("status", 64'(m_axis_tuser), 64'(w.st));
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (!rx_random) begin
        m_axis_tready <= 1'b1;
      end else if (wait_n > 0) begin
        wait_n--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) wait_n = $urandom_range(0, 13);
      end
    end
  end

  task automatic send_value(logic [63:0] v, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 13) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk); while (!s_axis_tready);
    pending_q.push_back(convert(v));
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] d);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EXPONENT_BITS) ew_reg = d[3:0];
    else mw_reg = d[5:0];
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[62:52] = 11'h7ff;
      1: v[62:52] = '0;
      2: v[62:52] = 11'(1023 + $urandom_range(0, 1100) - 550);
      3: v[51:0] = {52{1'b1}};
      default: v[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] vals[$];
    vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
             64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
             64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000, 64'h3fff_ffff_ffff_ffff,
             64'h7fef_ffff_ffff_ffff, 64'h0010_0000_0000_0000, 64'h3ff0_0000_1000_0000,
             64'h3ff0_0000_3000_0000, 64'h3ff0_0000_1000_0001, 64'h47ef_ffff_f000_0000,
             64'h3810_0000_0000_0000, 64'h380f_ffff_f000_0000, 64'hffff_ffff_ffff_ffff};
    foreach (vals[i]) send_value(vals[i], 1'b0);
  endtask

  task automatic test_formats();
    logic [7:0] ews[$], mws[$];
    ews = '{8'd2, 8'd11, 8'd0, 8'd15, 8'd5, 8'hf3};
    mws = '{8'd1, 8'd52, 8'd0, 8'd63, 8'd10, 8'hc7};
    foreach (ews[i]) begin
      write_reg(CFG_EXPONENT_BITS, ews[i]);
      write_reg(CFG_MANTISSA_BITS, mws[i]);
      repeat (60) send_value(rand_double(), 1'b1);
    end
  endtask

  task automatic test_random();
    repeat (8) begin
      write_reg(CFG_EXPONENT_BITS, 8'($urandom));
      write_reg(CFG_MANTISSA_BITS, 8'($urandom));
      repeat (30) send_value(rand_double(), $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic test_backpressure();
    -> hold_go;
    repeat (30) send_value(rand_double(), 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    ew_reg = EwReset;
    mw_reg = MwReset;
    rx_random = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    rx_random = 1'b1;
    test_formats();
    test_random();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("double_to_custom_float test passed");
    end else begin
      $display("double_to_custom_float test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("double_to_custom_float test failed");
    $finish;
  end

endmodule
